// ===== sv/typed_lane_allocator_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the typed lane allocator checker
// ---------------------------------------------------------------------------
`ifndef TYPED_LANE_ALLOCATOR_TOP_MACROS_SVH
`define TYPED_LANE_ALLOCATOR_TOP_MACROS_SVH

// Clocked check, muted while reset is high
`define TLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset
`define TLA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tla_pkg.sv =====
// ---------------------------------------------------------------------------
// tla_pkg
// Shared constants, codes and control structs of the typed lane allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tla_pkg;

  localparam int LANE_TOTAL = 16;
  localparam int LANE_W     = 4;
  localparam int COUNT_W    = $clog2(LANE_TOTAL + 1);
  localparam int TYPE_COUNT = 8;
  localparam int TYPE_W     = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
  localparam int BOX_W      = 8;
  localparam int IN_TYPE_W  = 8;
  localparam logic [BOX_W-1:0] LANE_LENGTH_RESET = 8'd8;

  typedef enum logic {
    FUNC_STORE   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_TYPE = 2'd1,
    STATUS_NO_FREE  = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_t;

  // free lane queue request
  typedef struct packed {
    logic              pop;
    logic              push;
    logic [LANE_W-1:0] lane;
  } free_ctl_t;

  // per-type lane queue request
  typedef struct packed {
    logic              append;
    logic              remove;
    logic [LANE_W-1:0] lane;
  } type_ctl_t;

  // per-type lane queue view for the selected type
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [LANE_W-1:0]  first;
    logic [LANE_W-1:0]  last;
  } type_view_t;

  // box counter write
  typedef struct packed {
    logic              we;
    logic [LANE_W-1:0] lane;
    logic [BOX_W-1:0]  value;
  } box_wr_t;

endpackage

// ===== sv/tla_free_queue.sv =====
// ---------------------------------------------------------------------------
// tla_free_queue
// Circular queue of free lanes, holding every lane in order after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tla_free_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  tla_pkg::free_ctl_t        ctl,
  output logic [tla_pkg::LANE_W-1:0] head_lane,
  output logic                      empty
);
  import tla_pkg::*;

  logic [LANE_W-1:0]  fifo [LANE_TOTAL];
  logic [LANE_W-1:0]  head;
  logic [COUNT_W-1:0] count;
  logic [LANE_W-1:0]  tail;

  assign tail      = head + count[LANE_W-1:0];
  assign head_lane = fifo[head];
  assign empty     = (count == '0);

  // pop from head, push at tail; never both in one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_TOTAL; i++) begin
        fifo[i] <= LANE_W'(i);
      end
      head  <= '0;
      count <= COUNT_W'(LANE_TOTAL);
    end else if (ctl.pop) begin
      head  <= head + 1'b1;
      count <= count - 1'b1;
    end else if (ctl.push) begin
      fifo[tail] <= ctl.lane;
      if (count < COUNT_W'(LANE_TOTAL)) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

// ===== sv/tla_type_queue.sv =====
// ---------------------------------------------------------------------------
// tla_type_queue
// Per-type lane queues kept as linked lists through a next-lane table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tla_type_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tla_pkg::TYPE_W-1:0] idx,
  input  tla_pkg::type_ctl_t         ctl,
  output tla_pkg::type_view_t        view
);
  import tla_pkg::*;

  logic [COUNT_W-1:0] count [TYPE_COUNT];
  logic [LANE_W-1:0]  first [TYPE_COUNT];
  logic [LANE_W-1:0]  last  [TYPE_COUNT];
  // lane that follows each lane in its type's queue
  logic [LANE_W-1:0]  nxt   [LANE_TOTAL];

  logic [LANE_W-1:0]  sel_first;

  assign sel_first  = first[idx];
  assign view.count = count[idx];
  assign view.first = sel_first;
  assign view.last  = last[idx];

  // queue counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TYPE_COUNT; i++) begin
        count[i] <= '0;
      end
    end else if (ctl.append) begin
      count[idx] <= count[idx] + 1'b1;
    end else if (ctl.remove) begin
      count[idx] <= count[idx] - 1'b1;
    end
  end

  // list pointers, meaningful only while the count is non-zero
  always_ff @(posedge clk) begin
    if (ctl.append) begin
      if (count[idx] == '0) begin
        first[idx] <= ctl.lane;
      end else begin
        nxt[last[idx]] <= ctl.lane;
      end
      last[idx] <= ctl.lane;
    end else if (ctl.remove) begin
      first[idx] <= nxt[sel_first];
    end
  end

endmodule

// ===== sv/tla_box_count.sv =====
// ---------------------------------------------------------------------------
// tla_box_count
// Box count of every lane, one read port and one write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tla_box_count (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tla_pkg::LANE_W-1:0] rd_lane,
  input  tla_pkg::box_wr_t           wr,
  output logic [tla_pkg::BOX_W-1:0]  rd_count
);
  import tla_pkg::*;

  logic [BOX_W-1:0] boxes [LANE_TOTAL];

  assign rd_count = boxes[rd_lane];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_TOTAL; i++) begin
        boxes[i] <= '0;
      end
    end else if (wr.we) begin
      boxes[wr.lane] <= wr.value;
    end
  end

endmodule

// ===== sv/typed_lane_allocator_top.sv =====
// ---------------------------------------------------------------------------
// typed_lane_allocator_top
// Lane allocator with a free lane queue and one lane queue per box type.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | request: type in tdata, func in tuser
//  m_*     | out | m_tvalid/m_tready  | result: lane, status, boxes in lane
//  cfg_*   | in  | cfg_valid/cfg_ready| lane capacity write, always ready
//
//  A request is registered in the input register, decided against the queue
//  and box count registers, and its result registered in the result
//  register, which raises m_tvalid; one request per cycle while no result stalls.
//  Reset (rst, synchronous) restores all lanes to the free queue in order,
//  empties every type queue, clears box counts and sets the capacity to 8.
//  A stalled result holds the input register; a new request is taken
//  whenever the input register empties or moves on in that cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_lane_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] box_type
  input  logic [0:0]  s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] lane, [5:4] status,
                                 // [13:6] boxes_in_lane, [15:14] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tla_pkg::*;

  logic                 in_vld;
  func_t                in_func;
  logic [IN_TYPE_W-1:0] in_type;
  logic [BOX_W-1:0]     lane_cap;

  logic                 fire;
  logic [TYPE_W-1:0]    ti;
  logic                 type_ok;
  logic                 need_new;

  free_ctl_t            free_ctl;
  type_ctl_t            type_ctl;
  type_view_t           view;
  box_wr_t              box_wr;
  logic [LANE_W-1:0]    head_free;
  logic                 free_empty;
  logic [BOX_W-1:0]     last_boxes;

  logic [LANE_W-1:0]    res_lane_next;
  status_t              res_status_next;
  logic [BOX_W-1:0]     res_boxes_next;

  logic [LANE_W-1:0]    res_lane;
  status_t              res_status;
  logic [BOX_W-1:0]     res_boxes;

  // handshakes
  assign fire      = in_vld && (!m_tvalid || m_tready);
  assign s_tready  = !in_vld || fire;
  assign cfg_ready = 1'b1;

  // lane capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_cap <= LANE_LENGTH_RESET;
    end else if (cfg_valid) begin
      lane_cap <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func <= func_t'(s_tuser[0]);
      in_type <= s_tdata;
    end
  end

  assign ti      = in_type[TYPE_W-1:0];
  assign type_ok = (in_type < IN_TYPE_W'(TYPE_COUNT));

  tla_free_queue u_free (
    .clk       (clk),
    .rst       (rst),
    .ctl       (free_ctl),
    .head_lane (head_free),
    .empty     (free_empty)
  );

  tla_type_queue u_type (
    .clk  (clk),
    .rst  (rst),
    .idx  (ti),
    .ctl  (type_ctl),
    .view (view)
  );

  tla_box_count u_boxes (
    .clk      (clk),
    .rst      (rst),
    .rd_lane  (view.last),
    .wr       (box_wr),
    .rd_count (last_boxes)
  );

  // newest lane is full, or the type has none yet
  assign need_new = (view.count == '0) || (last_boxes >= lane_cap);

  // request decision; a free lane always carries a zero box count
  always_comb begin
    free_ctl        = '0;
    type_ctl        = '0;
    box_wr          = '0;
    res_lane_next   = '0;
    res_status_next = STATUS_OK;
    res_boxes_next  = '0;
    if (!type_ok) begin
      res_status_next = STATUS_BAD_TYPE;
    end else if (in_func == FUNC_STORE) begin
      if (need_new) begin
        if (free_empty) begin
          res_status_next = STATUS_NO_FREE;
        end else begin
          free_ctl.pop    = fire;
          type_ctl.append = fire;
          type_ctl.lane   = head_free;
          res_lane_next   = head_free;
          res_boxes_next  = BOX_W'(1);
        end
      end else begin
        res_lane_next  = view.last;
        res_boxes_next = last_boxes + 1'b1;
      end
      box_wr.we    = fire && (res_status_next == STATUS_OK);
      box_wr.lane  = res_lane_next;
      box_wr.value = res_boxes_next;
    end else begin
      if (view.count == '0) begin
        res_status_next = STATUS_EMPTY;
      end else begin
        type_ctl.remove = fire;
        free_ctl.push   = fire;
        free_ctl.lane   = view.first;
        box_wr.we       = fire;
        box_wr.lane     = view.first;
        box_wr.value    = '0;
        res_lane_next   = view.first;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_lane   <= res_lane_next;
      res_status <= res_status_next;
      res_boxes  <= res_boxes_next;
    end
  end

  assign m_tdata = {2'b00, res_boxes, res_status, res_lane};

endmodule

// ===== sv/tla_checker.sv =====
// ---------------------------------------------------------------------------
// tla_checker
// Port-level checks of the typed lane allocator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "typed_lane_allocator_top_macros.svh"

module tla_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import tla_pkg::*;

  // a stalled result holds its value
  `TLA_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
              "result dropped or changed while stalled")

  // a failed request reports lane 0 and no boxes
  `TLA_ASSERT(a_fail_zero,
              m_tvalid && (m_tdata[5:4] != STATUS_OK) |->
                (m_tdata[3:0] == '0) && (m_tdata[13:6] == '0),
              "failed request with non-zero lane or box count")

  // requests are only refused while a result waits to be taken
  `TLA_ASSERT(a_backpressure, !s_tready |-> m_tvalid && !m_tready,
              "request refused with output side free")

  // reset empties the result register
  `TLA_ASSERT_RST(a_reset, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind typed_lane_allocator_top tla_checker u_tla_checker (.*);
